// ----- hdl/sb64_pkg.sv -----
`timescale 1ns / 1ps
// Package for the strict base64 decoder: result record, status codes,
// FIFO sizing and the alphabet lookup. No dependencies.
package sb64_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = 2;
	localparam int unsigned FIFO_CNT_W = 3;
	localparam int unsigned MAX_PUSH   = 3;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_CHAR   = 3'd1;
	localparam logic [2:0] ST_BAD_PAD    = 3'd2;
	localparam logic [2:0] ST_NONCANON   = 3'd3;
	localparam logic [2:0] ST_INCOMPLETE = 3'd4;
	localparam logic [2:0] ST_TOO_LARGE  = 3'd5;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] status;
		logic       last;
	} result_t;

	// Alphabet lookup: bit 6 flags a member of the alphabet, bits 5:0 hold its index.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			return {1'b1, d[5:0]};
		end
		if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61 + 8'd26;
			return {1'b1, d[5:0]};
		end
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30 + 8'd52;
			return {1'b1, d[5:0]};
		end
		if (c == 8'h2B) return {1'b1, 6'd62};
		if (c == 8'h2F) return {1'b1, 6'd63};
		return 7'd0;
	endfunction

endpackage

// ----- hdl/strict_base64_decoder.sv -----
`timescale 1ns / 1ps
// Strict base64 decoder top level: input register, decode logic and result FIFO.
// Depends on sb64_pkg.
//
// Takes one base64 character per item (standard alphabet, padded) and returns
// decoded bytes, one per output item, or a single error item per failed
// stream. Throughput is one character per cycle while in_stall is low: each
// character is held in the input register and decoded there in a single
// pass; a complete group of four pushes up to three results at once into a
// four-entry result FIFO that drains one item per cycle while out_stall is
// low. A character is decoded only once the FIFO has a free slot for every
// result that it pushes (none for the first three characters of a group, one
// for an error, up to three for a group's last character), so four
// characters per three bytes flow without a gap. A stalled output side
// backs up into in_stall as soon as the FIFO cannot take the waiting
// character's results; the input register holds that character meanwhile.
// After an error item (out_end set, out_byte zero) all characters up to the
// one flagged last are dropped. max_bytes_q resets to 16777216 and is
// written through cfg_we / cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce.
module strict_base64_decoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [31:0]               cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                in_char,
	input  logic                      in_last,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                out_byte,
	output logic [2:0]                out_status,
	output logic                      out_end
);
	import sb64_pkg::*;

	// configuration
	logic [31:0] max_bytes_q;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// stream state
	logic [1:0]  pos_q;
	logic [17:0] acc_q;
	logic        third_pad_q;
	logic [32:0] emitted_q;
	logic        discard_q;

	logic [1:0]  pos_d;
	logic [17:0] acc_d;
	logic        third_pad_d;
	logic [32:0] emitted_d;
	logic        discard_d;

	// result FIFO
	result_t                 fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   cnt_q;

	// decode signals
	logic        room;
	logic        proc_fire;
	logic        in_fire;
	logic        out_fire;
	logic        is_pad;
	logic [6:0]  lookup;
	logic        err;
	logic [2:0]  err_code;
	logic [5:0]  sextet;
	logic [1:0]  pad_n;
	logic [1:0]  byte_n;
	logic [23:0] bits;
	logic [32:0] emitted_sum;
	logic [1:0]  need_n;
	logic [1:0]  push_n;
	result_t     res [MAX_PUSH];

	// Decode only when the FIFO has a slot for each result the character pushes.
	assign need_n    = discard_q ? 2'd0 :
	                   err ? 2'd1 :
	                   (pos_q != 2'd3) ? 2'd0 : byte_n;
	assign room      = (cnt_q + FIFO_CNT_W'(need_n)) <= FIFO_CNT_W'(FIFO_DEPTH);
	assign proc_fire = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = cnt_q != '0;
	assign out_fire  = out_valid && !out_stall;

	assign out_byte   = fifo_q[rd_ptr_q].data;
	assign out_status = fifo_q[rd_ptr_q].status;
	assign out_end    = fifo_q[rd_ptr_q].last;

	assign is_pad      = char_s1 == PAD_CHAR;
	assign lookup      = sextet_of(char_s1);
	assign bits        = {acc_q, sextet};
	assign byte_n      = 2'd3 - pad_n;
	assign emitted_sum = emitted_q + {31'd0, byte_n};

	// Classify the character: padding rules, then the alphabet, then group checks.
	always_comb begin
		err         = 1'b0;
		err_code    = ST_OK;
		sextet      = 6'd0;
		pad_n       = 2'd0;
		if (is_pad) begin
			if (pos_q < 2'd2) begin
				err      = 1'b1;
				err_code = ST_BAD_PAD;
			end else if (pos_q == 2'd3) begin
				if (!last_s1) begin
					err      = 1'b1;
					err_code = ST_BAD_PAD;
				end else begin
					pad_n = third_pad_q ? 2'd2 : 2'd1;
				end
			end
		end else if (pos_q == 2'd3 && third_pad_q) begin
			err      = 1'b1;
			err_code = ST_BAD_PAD;
		end else if (!lookup[6]) begin
			err      = 1'b1;
			err_code = ST_BAD_CHAR;
		end else begin
			sextet = lookup[5:0];
		end
		// group-level checks once the character itself is acceptable
		if (!err) begin
			if (pos_q != 2'd3) begin
				if (last_s1) begin
					err      = 1'b1;
					err_code = ST_INCOMPLETE;
				end
			end else if ((pad_n == 2'd2 && bits[15:0] != 16'd0) ||
			             (pad_n == 2'd1 && bits[7:0] != 8'd0)) begin
				err      = 1'b1;
				err_code = ST_NONCANON;
			end else if (emitted_sum > {1'b0, max_bytes_q}) begin
				err      = 1'b1;
				err_code = ST_TOO_LARGE;
			end
		end
	end

	// Next stream state and the results to push.
	always_comb begin
		pos_d       = pos_q;
		acc_d       = acc_q;
		third_pad_d = third_pad_q;
		emitted_d   = emitted_q;
		discard_d   = discard_q;
		push_n      = 2'd0;
		for (int k = 0; k < MAX_PUSH; k++) begin
			res[k] = '0;
		end
		if (proc_fire) begin
			if (discard_q) begin
				// drop characters until the last one, then start afresh
				if (last_s1) begin
					discard_d = 1'b0;
				end
			end else if (err) begin
				push_n        = 2'd1;
				res[0].status = err_code;
				res[0].last   = 1'b1;
				pos_d         = 2'd0;
				acc_d         = '0;
				third_pad_d   = 1'b0;
				emitted_d     = '0;
				discard_d     = !last_s1;
			end else if (pos_q != 2'd3) begin
				acc_d = {acc_q[11:0], sextet};
				pos_d = pos_q + 2'd1;
				if (is_pad) begin
					third_pad_d = 1'b1;
				end
			end else begin
				push_n = byte_n;
				for (int k = 0; k < MAX_PUSH; k++) begin
					res[k].data   = bits[23 - 8*k -: 8];
					res[k].status = ST_OK;
					res[k].last   = last_s1 && (2'(k) + 2'd1 == byte_n);
				end
				pos_d       = 2'd0;
				acc_d       = '0;
				third_pad_d = 1'b0;
				emitted_d   = last_s1 ? 33'd0 : emitted_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= 32'd16777216;
		end else if (cfg_we) begin
			max_bytes_q <= cfg_wdata;
		end
	end

	// Input register: load on accept, empty once decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (proc_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 2'd0;
			acc_q       <= '0;
			third_pad_q <= 1'b0;
			emitted_q   <= '0;
			discard_q   <= 1'b0;
		end else begin
			pos_q       <= pos_d;
			acc_q       <= acc_d;
			third_pad_q <= third_pad_d;
			emitted_q   <= emitted_d;
			discard_q   <= discard_d;
		end
	end

	// Result FIFO storage: up to three writes per cycle at consecutive slots.
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_PUSH; k++) begin
			if (2'(k) < push_n) begin
				fifo_q[wr_ptr_q + FIFO_PTR_W'(k)] <= res[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_n);
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(out_fire);
		end
	end

`ifndef SYNTHESIS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result FIFO overfilled");

	a_err_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_status != ST_OK) |-> (out_end && out_byte == 8'd0))
		else $error("error item without end flag or with data");

	a_stream_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(proc_fire && last_s1) |=> (pos_q == 2'd0 && !discard_q && emitted_q == '0
			&& !third_pad_q))
		else $error("stream state not cleared after last character");

	a_err_discard: assert property (@(posedge clk) disable iff (!arst_n)
		(proc_fire && !discard_q && err && !last_s1) |=> discard_q)
		else $error("error not followed by discarding");

	a_no_push_discard: assert property (@(posedge clk) disable iff (!arst_n)
		discard_q |-> push_n == 2'd0)
		else $error("result pushed while discarding");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for strict_base64_decoder: directed and random base64
// streams, checked item by item against an in-bench decoder.
// Depends on sb64_pkg and the strict_base64_decoder RTL.
module tb;
	import sb64_pkg::*;

	localparam string       ALPHABET       =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam logic [31:0] RESET_LIMIT    = 32'd16777216;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned DRAIN_LIMIT    = 20000;
	localparam int unsigned HOLD_CYCLES    = 80;
	localparam int unsigned RANDOM_ITEMS   = 48;
	localparam int unsigned REPORT_LIMIT   = 10;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN
	} stall_mode_e;

	typedef enum int {
		FLAV_CLEAN,
		FLAV_BAD_CHAR,
		FLAV_TRUNCATE,
		FLAV_PAD_SKEW,
		FLAV_PAD_MIDDLE,
		FLAV_NOISE
	} flavour_e;

	// Clock, reset and block inputs, all known from time zero
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = 32'd0;
	logic        in_valid  = 1'b0;
	logic [7:0]  in_char   = 8'd0;
	logic        in_last   = 1'b0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic [2:0]  out_status;
	logic        out_end;

	// Decoder state mirrored in the bench
	logic [1:0]  grp_pos;
	logic [17:0] sextet_acc;
	logic        third_pad;
	logic [32:0] bytes_emitted;
	logic        skipping;
	logic [31:0] byte_limit;

	result_t     decoded_fifo[$];
	int unsigned mismatch_count;
	int unsigned live_chars;
	int unsigned burst_left;

	// Output-side stall control
	logic        hold_request;
	int unsigned hold_left;
	int unsigned phase_left;
	stall_mode_e stall_mode;
	logic [15:0] stall_pattern;
	logic [3:0]  pattern_idx;

	strict_base64_decoder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_char    (in_char),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.out_status (out_status),
		.out_end    (out_end)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Position of c in the alphabet, or -1 for a foreign byte
	function automatic int alphabet_index(input logic [7:0] c);
		for (int i = 0; i < 64; i++) begin
			if (ALPHABET[i] == c)
				return i;
		end
		return -1;
	endfunction

	// Start a fresh stream; the byte limit is kept
	task automatic clear_stream;
		grp_pos       = 2'd0;
		sextet_acc    = 18'd0;
		third_pad     = 1'b0;
		bytes_emitted = 33'd0;
		skipping      = 1'b0;
	endtask

	// Queue the single error item, then skip to the end of the stream unless
	// this character already closes it
	task automatic push_error(input logic [2:0] status, input logic is_last);
		result_t r;
		r.data   = 8'h00;
		r.status = status;
		r.last   = 1'b1;
		decoded_fifo.insert(decoded_fifo.size(), r);
		clear_stream();
		if (!is_last)
			skipping = 1'b1;
	endtask

	// Work out the items that one accepted character causes
	task automatic decode_char(input logic [7:0] c, input logic is_last);
		logic [1:0]  pos;
		logic [5:0]  sext;
		int unsigned npad;
		int unsigned count;
		int          idx;
		logic [23:0] bits;
		result_t     r;
		pos  = grp_pos;
		sext = 6'd0;
		npad = 0;
		if (skipping) begin
			if (is_last)
				clear_stream();
			return;
		end
		live_chars++;
		if (c == PAD_CHAR) begin
			// pad too early in the group, or a closing pad that does not end the stream
			if (pos < 2'd2) begin
				push_error(ST_BAD_PAD, is_last);
				return;
			end
			if (pos == 2'd2) begin
				third_pad = 1'b1;
			end else begin
				if (!is_last) begin
					push_error(ST_BAD_PAD, is_last);
					return;
				end
				npad = third_pad ? 2 : 1;
			end
		end else begin
			// a pad in the third slot must be followed by a pad; this beats the alphabet check
			if (pos == 2'd3 && third_pad) begin
				push_error(ST_BAD_PAD, is_last);
				return;
			end
			idx = alphabet_index(c);
			if (idx < 0) begin
				push_error(ST_BAD_CHAR, is_last);
				return;
			end
			sext = idx[5:0];
		end
		if (pos < 2'd3) begin
			if (is_last) begin
				push_error(ST_INCOMPLETE, is_last);
				return;
			end
			sextet_acc = {sextet_acc[11:0], sext};
			grp_pos    = pos + 2'd1;
			return;
		end
		bits  = {sextet_acc, sext};
		count = 3 - npad;
		if ((npad == 2 && bits[15:0] != 16'd0) || (npad == 1 && bits[7:0] != 8'd0)) begin
			push_error(ST_NONCANON, is_last);
			return;
		end
		// the whole group is refused when it would overrun the limit
		if (bytes_emitted + 33'(count) > {1'b0, byte_limit}) begin
			push_error(ST_TOO_LARGE, is_last);
			return;
		end
		for (int k = 0; k < count; k++) begin
			r.data   = bits[23 - 8 * k -: 8];
			r.status = ST_OK;
			r.last   = is_last && (k + 1 == count);
			decoded_fifo.insert(decoded_fifo.size(), r);
		end
		bytes_emitted = bytes_emitted + 33'(count);
		grp_pos       = 2'd0;
		sextet_acc    = 18'd0;
		third_pad     = 1'b0;
		if (is_last)
			clear_stream();
	endtask

	task automatic report_mismatch(input string what, input result_t want);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t mismatch (%s): expected %h/%0d/%b, got %h/%0d/%b",
				$realtime, what, want.data, want.status, want.last,
				out_byte, out_status, out_end);
	endtask

	// Predict on every accepted character, then compare every accepted item
	// against the oldest prediction. Both use the values from before the edge.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				decode_char(in_char, in_last);
			if (out_valid && !out_stall) begin
				if (decoded_fifo.size() == 0) begin
					want = '0;
					report_mismatch("no item expected", want);
				end else begin
					want = decoded_fifo.pop_front();
					if (want.data != out_byte || want.status != out_status
							|| want.last != out_end)
						report_mismatch("field differs", want);
				end
			end
		end
	end

	// Receiver stalls: phases of no stall, random stall and a repeating
	// pattern, with a long hold-off whenever a test asks for one
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES - 1;
			out_stall    <= 1'b1;
		end else begin
			if (phase_left == 0) begin
				stall_mode    = stall_mode_e'($urandom_range(0, 2));
				phase_left    = $urandom_range(16, 120);
				stall_pattern = 16'($urandom);
			end else begin
				phase_left--;
			end
			case (stall_mode)
				STALL_NONE: begin
					out_stall <= 1'b0;
				end
				STALL_RANDOM: begin
					out_stall <= ($urandom_range(0, 2) == 0);
				end
				default: begin
					out_stall   <= stall_pattern[pattern_idx];
					pattern_idx = pattern_idx + 4'd1;
				end
			endcase
		end
	end

	// Offer one character and hold it until the block takes it. Characters go
	// out in bursts; a gap of idle cycles opens each new burst.
	task automatic send_char(input logic [7:0] c, input logic is_last);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
				: $urandom_range(1, 10);
		end
		in_valid <= 1'b1;
		in_char  <= c;
		in_last  <= is_last;
		do
			@(posedge clk);
		while (in_stall);
		burst_left--;
	endtask

	task automatic send_text(input string s, input logic end_flag);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], end_flag && (i == s.len() - 1));
	endtask

	// Drop valid and wait until every predicted item has come out, then let
	// the pipeline settle
	task automatic wait_for_results;
		int unsigned waited;
		waited   = 0;
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (decoded_fifo.size() != 0 && waited < DRAIN_LIMIT);
		if (decoded_fifo.size() != 0) begin
			mismatch_count++;
			$display("%0t %0d items never arrived", $realtime, decoded_fifo.size());
			decoded_fifo.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// Write the byte limit; only called with the block idle
	task automatic write_limit(input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		byte_limit = value;
	endtask

	// Encode n random bytes as padded base64 and append the characters
	task automatic encode_bytes(input int n, ref logic [7:0] chars[$]);
		logic [23:0] w;
		int          left;
		for (int g = 0; g < n; g += 3) begin
			left = n - g;
			w    = 24'($urandom);
			if (left == 1)
				w[15:0] = 16'd0;
			else if (left == 2)
				w[7:0] = 8'd0;
			chars.insert(chars.size(), ALPHABET[w[23:18]]);
			chars.insert(chars.size(), ALPHABET[w[17:12]]);
			chars.insert(chars.size(), (left == 1) ? PAD_CHAR : ALPHABET[w[11:6]]);
			chars.insert(chars.size(), (left < 3) ? PAD_CHAR : ALPHABET[w[5:0]]);
		end
	endtask

	// One stream: mostly well formed with random content, the rest damaged
	// in one way or another, or plain noise
	task automatic send_random_stream;
		logic [7:0] chars[$];
		int         n;
		int         pick;
		int         pos;
		flavour_e   flavour;
		n    = $urandom_range(1, 12);
		pick = $urandom_range(0, 19);
		if (pick < 12)
			flavour = FLAV_CLEAN;
		else if (pick < 14)
			flavour = FLAV_BAD_CHAR;
		else if (pick < 16)
			flavour = FLAV_TRUNCATE;
		else if (pick < 17)
			flavour = FLAV_PAD_SKEW;
		else if (pick < 18)
			flavour = FLAV_PAD_MIDDLE;
		else
			flavour = FLAV_NOISE;
		if (flavour == FLAV_NOISE) begin
			repeat ($urandom_range(1, 6))
				chars.insert(chars.size(), 8'($urandom));
		end else begin
			encode_bytes(n, chars);
		end
		case (flavour)
			FLAV_BAD_CHAR: begin
				chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom);
			end
			FLAV_TRUNCATE: begin
				repeat ($urandom_range(1, 3))
					void'(chars.pop_back());
			end
			FLAV_PAD_SKEW: begin
				// set a discarded bit in a padded group, or drop a stray pad in
				if (n % 3 == 1) begin
					pos        = chars.size() - 3;
					chars[pos] = ALPHABET[alphabet_index(chars[pos]) | 1];
				end else if (n % 3 == 2) begin
					pos        = chars.size() - 2;
					chars[pos] = ALPHABET[alphabet_index(chars[pos]) | 1];
				end else begin
					chars[$urandom_range(0, chars.size() - 1)] = PAD_CHAR;
				end
			end
			FLAV_PAD_MIDDLE: begin
				// carry on past a possibly padded group
				encode_bytes($urandom_range(1, 6), chars);
			end
			default: begin
			end
		endcase
		for (int i = 0; i < chars.size(); i++)
			send_char(chars[i], i == chars.size() - 1);
	endtask

	// Full groups and both pad forms, covering the alphabet extremes
	task automatic test_clean_groups;
		send_text("TWFu", 1'b1);
		send_text("+/9z////AAAATWE=", 1'b1);
		send_text("TQ==", 1'b1);
	endtask

	// Pad in the wrong place: too early, mismatched, not final, and an
	// unfinished group ending in a pad
	task automatic test_padding_errors;
		send_text("=", 1'b1);
		send_text("T=", 1'b0);
		send_text("Q", 1'b1);
		send_text("TW=A", 1'b1);
		send_text("TW=", 1'b1);
		send_text("TQ==", 1'b0);
		send_text("AB", 1'b1);
	endtask

	// Foreign bytes at both ends of the range, leftover bits, short stream
	task automatic test_char_errors;
		send_char(8'h00, 1'b0);
		send_text("A", 1'b1);
		send_char(8'hFF, 1'b1);
		send_text("TR==", 1'b1);
		send_text("TWF=", 1'b1);
		send_text("TWF", 1'b1);
	endtask

	// Limits of zero, one that a second group overruns, and the widest
	task automatic test_byte_limit;
		wait_for_results();
		write_limit(32'd0);
		send_text("TQ==", 1'b1);
		wait_for_results();
		write_limit(32'd4);
		send_text("TWFuTWFu", 1'b1);
		send_text("TWFuTQ==", 1'b1);
		wait_for_results();
		write_limit(32'hFFFF_FFFF);
		send_text("TWFuTWE=", 1'b1);
	endtask

	// Hold the receiver off while the sender keeps offering, so the result
	// buffer fills and the input stalls
	task automatic test_backpressure;
		wait_for_results();
		burst_left   = 100;
		hold_request = 1'b1;
		send_text("TWFuTWFuTWFuTWFuTWFuTWFu", 1'b1);
		send_text("AAAA", 1'b1);
		wait_for_results();
	endtask

	// Random streams in phases, a fresh limit for each phase
	task automatic test_random_streams;
		int unsigned target;
		logic [31:0] limit_value;
		for (int phase = 0; phase < 4; phase++) begin
			wait_for_results();
			case (phase)
				0:       limit_value = 32'hFFFF_FFFF;
				1:       limit_value = $urandom_range(0, 12);
				2:       limit_value = $urandom_range(3, 30);
				default: limit_value = RESET_LIMIT;
			endcase
			write_limit(limit_value);
			target = live_chars + RANDOM_ITEMS / 4;
			while (live_chars < target)
				send_random_stream();
		end
	endtask

	initial begin
		byte_limit     = RESET_LIMIT;
		mismatch_count = 0;
		live_chars     = 0;
		burst_left     = 0;
		hold_request   = 1'b0;
		hold_left      = 0;
		phase_left     = 0;
		stall_mode     = STALL_NONE;
		stall_pattern  = 16'd0;
		pattern_idx    = 4'd0;
		clear_stream();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_clean_groups();
		test_padding_errors();
		test_char_errors();
		test_byte_limit();
		test_backpressure();
		test_random_streams();

		wait_for_results();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
